### rtl/frt_pkg.sv
`timescale 1ns / 1ps
package frt_pkg;
  localparam int FRAME_SLOTS   = 8;
  localparam int MAX_FRAGMENTS = 32;
  localparam int SLOT_W        = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int FRAG_W        = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int CNT_W         = $clog2(MAX_FRAGMENTS + 1);
  localparam int ADDR_W        = SLOT_W + FRAG_W;
  localparam int IDX_OUT_W     = 5;
  localparam int IN_TDATA_W    = 168;
  localparam int OUT_TDATA_W   = 184;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_KEYMASK = 1'b1;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [31:0]       frame_id;
    logic [62:0]       pts;
    logic              key;
    logic [CNT_W-1:0]  count;
    logic [31:0]       drops;
    logic [31:0]       fulls;
  } job_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
  } hwr_t;

  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
  } rel_t;
endpackage

### rtl/frt_queue.sv
`timescale 1ns / 1ps
module frt_queue import frt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);
  job_t     mem_r [2];
  logic     wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wp_r] <= push_job;
        wp_r        <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### rtl/frt_front.sv
`timescale 1ns / 1ps
module frt_front import frt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       kind,
  input  logic [31:0]      frame_id,
  input  logic [62:0]      pts,
  input  logic [7:0]       packet_count,
  input  logic [7:0]       packet_index,
  input  logic [7:0]       flags,
  input  logic [15:0]      fragment_handle,
  input  logic [31:0]      now_time,
  input  logic [15:0]      timeout_ms,
  input  logic [7:0]       keyframe_flag_mask,
  output hwr_t             hwr,
  output logic             push,
  output job_t             push_job,
  input  logic             q_full,
  input  rel_t             rel,
  output logic [FRAME_SLOTS-1:0] lock
);
  typedef enum logic [1:0] {F_IDLE, F_SCAN, F_LOOK, F_APPLY} fstate_t;
  fstate_t state_r;

  logic [1:0]  kind_r;
  logic [31:0] fid_r, now_r;
  logic [62:0] pts_r;
  logic [7:0]  cnt_r, idx_r, flags_r;
  logic [15:0] handle_r;

  logic [FRAME_SLOTS-1:0] valid_r, lock_r;
  logic [31:0]        s_fid_r     [FRAME_SLOTS];
  logic [62:0]        s_pts_r     [FRAME_SLOTS];
  logic [CNT_W-1:0]   s_count_r   [FRAME_SLOTS];
  logic [CNT_W-1:0]   s_rec_r     [FRAME_SLOTS];
  logic               s_key_r     [FRAME_SLOTS];
  logic [31:0]        s_created_r [FRAME_SLOTS];
  logic [MAX_FRAGMENTS-1:0] s_bm_r [FRAME_SLOTS];
  logic [31:0] drops_r, fulls_r;
  logic [SLOT_W-1:0] tgt_r;
  logic              is_new_r;

  logic [FRAME_SLOTS-1:0] stale;
  logic [32:0]            drop_sum;
  logic                   pkt_ok, hit_any, free_any;
  logic [SLOT_W-1:0]      hit_slot, free_slot;
  logic [CNT_W-1:0]       cur_count, cur_rec, rec_nxt;
  logic [MAX_FRAGMENTS-1:0] cur_bm;
  logic [FRAG_W-1:0]      idx_n;
  logic                   cnt_match, newbit, complete, go;

  assign in_ready = (state_r == F_IDLE);
  assign lock     = lock_r;
  assign idx_n    = idx_r[FRAG_W-1:0];

  always_comb begin
    drop_sum = {1'b0, drops_r};
    for (int s = 0; s < FRAME_SLOTS; s++) begin
      stale[s] = valid_r[s] && ((now_r - s_created_r[s]) > {16'd0, timeout_ms});
      drop_sum = drop_sum + {32'd0, stale[s]};
    end
  end

  always_comb begin
    pkt_ok = (kind_r == 2'd0) && (cnt_r != 8'd0) && (idx_r < cnt_r)
             && ({24'd0, cnt_r} <= 32'(MAX_FRAGMENTS));
    hit_any = 1'b0; hit_slot = '0; free_any = 1'b0; free_slot = '0;
    for (int s = FRAME_SLOTS - 1; s >= 0; s--) begin
      if (valid_r[s] && s_fid_r[s] == fid_r) begin
        hit_any = 1'b1; hit_slot = SLOT_W'(s);
      end
      if (!valid_r[s]) begin
        free_any = 1'b1; free_slot = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    cur_count = is_new_r ? cnt_r[CNT_W-1:0] : s_count_r[tgt_r];
    cur_rec   = is_new_r ? '0 : s_rec_r[tgt_r];
    cur_bm    = is_new_r ? '0 : s_bm_r[tgt_r];
    cnt_match = ({{(8-CNT_W){1'b0}}, cur_count} == cnt_r);
    newbit    = !cur_bm[idx_n];
    rec_nxt   = cur_rec + {{(CNT_W-1){1'b0}}, newbit};
    complete  = cnt_match && ({{(8-CNT_W){1'b0}}, rec_nxt} == cnt_r);
    go        = !(is_new_r && lock_r[tgt_r]) && !(complete && q_full);
  end

  assign push = (state_r == F_APPLY) && go && complete;
  always_comb begin
    push_job.slot     = tgt_r;
    push_job.frame_id = is_new_r ? fid_r : s_fid_r[tgt_r];
    push_job.pts      = is_new_r ? pts_r : s_pts_r[tgt_r];
    push_job.key      = is_new_r ? ((flags_r & keyframe_flag_mask) != 8'd0) : s_key_r[tgt_r];
    push_job.count    = cur_count;
    push_job.drops    = drops_r;
    push_job.fulls    = fulls_r;
    hwr.vld  = (state_r == F_APPLY) && go && cnt_match && newbit;
    hwr.addr = {tgt_r, idx_n};
    hwr.data = handle_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      valid_r <= '0;
      lock_r  <= '0;
      drops_r <= '0;
      fulls_r <= '0;
    end else begin
      if (rel.vld) lock_r[rel.slot] <= 1'b0;
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            kind_r <= kind; fid_r <= frame_id; pts_r <= pts; cnt_r <= packet_count;
            idx_r <= packet_index; flags_r <= flags; handle_r <= fragment_handle;
            now_r <= now_time;
            state_r <= F_SCAN;
          end
        end
        F_SCAN: begin
          valid_r <= valid_r & ~stale;
          drops_r <= drop_sum[32] ? 32'hFFFF_FFFF : drop_sum[31:0];
          state_r <= F_LOOK;
        end
        F_LOOK: begin
          tgt_r    <= hit_any ? hit_slot : free_slot;
          is_new_r <= !hit_any;
          if (pkt_ok && (hit_any || free_any)) begin
            state_r <= F_APPLY;
          end else begin
            if (pkt_ok && fulls_r != 32'hFFFF_FFFF) fulls_r <= fulls_r + 32'd1;
            state_r <= F_IDLE;
          end
        end
        F_APPLY: begin
          if (go) begin
            if (is_new_r) begin
              valid_r[tgt_r]     <= 1'b1;
              s_fid_r[tgt_r]     <= fid_r;
              s_pts_r[tgt_r]     <= pts_r;
              s_count_r[tgt_r]   <= cnt_r[CNT_W-1:0];
              s_key_r[tgt_r]     <= (flags_r & keyframe_flag_mask) != 8'd0;
              s_created_r[tgt_r] <= now_r;
            end
            if (cnt_match) begin
              s_rec_r[tgt_r] <= rec_nxt;
              s_bm_r[tgt_r]  <= cur_bm | (MAX_FRAGMENTS'(1) << idx_n);
            end
            if (complete) begin
              valid_r[tgt_r] <= 1'b0;
              lock_r[tgt_r]  <= 1'b1;
            end
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end
endmodule

### rtl/frt_back.sv
`timescale 1ns / 1ps
module frt_back import frt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  hwr_t       hwr,
  input  logic       q_empty,
  input  job_t       q_head,
  output logic       pop,
  output rel_t       rel,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [31:0] done_frame_id,
  output logic [62:0] done_pts,
  output logic       key_frame,
  output logic [15:0] out_handle,
  output logic [IDX_OUT_W-1:0] out_index,
  output logic       last,
  output logic [31:0] dropped_frames,
  output logic [31:0] full_drops
);
  typedef enum logic [1:0] {B_IDLE, B_READ, B_OUT, B_WAIT} bstate_t;
  bstate_t state_r;

  logic [15:0]      hmem [FRAME_SLOTS*MAX_FRAGMENTS];
  logic [15:0]      rdata_r;
  job_t             job_r;
  logic [CNT_W-1:0] i_r;
  logic             last_r, valid_r;

  assign pop       = (state_r == B_IDLE) && !q_empty;
  assign out_valid = valid_r;
  assign last      = last_r;
  assign rel.vld   = (state_r == B_WAIT) && out_ready && last_r;
  assign rel.slot  = job_r.slot;

  always_ff @(posedge clk) begin
    if (hwr.vld) hmem[hwr.addr] <= hwr.data;
    rdata_r <= hmem[{job_r.slot, i_r[FRAG_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            job_r   <= q_head;
            i_r     <= '0;
            state_r <= B_READ;
          end
        end
        B_READ: state_r <= B_OUT;
        B_OUT: begin
          done_frame_id  <= job_r.frame_id;
          done_pts       <= job_r.pts;
          key_frame      <= job_r.key;
          out_handle     <= rdata_r;
          out_index      <= IDX_OUT_W'(i_r);
          last_r         <= (i_r + CNT_W'(1)) == job_r.count;
          dropped_frames <= job_r.drops;
          full_drops     <= job_r.fulls;
          valid_r        <= 1'b1;
          state_r        <= B_WAIT;
        end
        B_WAIT: begin
          if (out_ready) begin
            valid_r <= 1'b0;
            i_r     <= i_r + CNT_W'(1);
            state_r <= last_r ? B_IDLE : B_READ;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule

### rtl/fragment_reassembly_table.sv
`timescale 1ns / 1ps
// Fragment reassembly table.
// in_* stream: one packet per transfer; in_tuser carries the packet kind.
// The front end takes each packet through capture, stale-slot sweep, slot
// lookup and table update, with no update for a packet dropped at lookup; it
// waits in the update step only when a new frame would claim a slot whose
// handles are still being sent, or when the job queue is full.
// A completed frame becomes a job in a two-entry queue. The back end reads
// handles from the handle memory and sends one result per fragment in index
// order on out_*, tlast on the final one. For each result it reads the handle,
// registers the result and holds it until out_tready; the next read starts
// only after the previous result is accepted. A stall on out_* holds the result
// register and lets the front end keep accepting packets until the queue fills.
// Reset (synchronous, rst_n low) frees all slots, clears both counters and
// restores timeout_ms = 500 and keyframe_flag_mask = 1; no clearing sweep.
// cfg_* is APB: timeout_ms at 0x0, keyframe_flag_mask at 0x4; write only
// while idle.
module fragment_reassembly_table import frt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // frame_id, pts, packet_count, packet_index, flags, fragment_handle, now_time
  input  logic [IN_TDATA_W-1:0] in_tdata,
  // kind
  input  logic [1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // done_frame_id, done_pts, key_frame, out_handle, out_index, dropped_frames,
  // full_drops
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic out_tlast,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  logic [15:0] timeout_r;
  logic [7:0]  keymask_r;
  hwr_t hwr;
  rel_t rel;
  job_t push_job, q_head;
  logic push, q_full, pop, q_empty;
  logic [FRAME_SLOTS-1:0] lock;
  logic [31:0] d_fid, d_drops, d_fulls;
  logic [62:0] d_pts;
  logic d_key;
  logic [15:0] d_handle;
  logic [IDX_OUT_W-1:0] d_index;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_KEYMASK) ? {24'd0, keymask_r} : {16'd0, timeout_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 16'd500;
      keymask_r <= 8'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == REG_TIMEOUT) timeout_r <= cfg_pwdata[15:0];
      else keymask_r <= cfg_pwdata[7:0];
    end
  end

  frt_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .kind(in_tuser), .frame_id(in_tdata[31:0]), .pts(in_tdata[94:32]),
    .packet_count(in_tdata[102:95]), .packet_index(in_tdata[110:103]),
    .flags(in_tdata[118:111]), .fragment_handle(in_tdata[134:119]),
    .now_time(in_tdata[166:135]),
    .timeout_ms(timeout_r), .keyframe_flag_mask(keymask_r),
    .hwr, .push, .push_job, .q_full, .rel, .lock
  );

  frt_queue u_queue (
    .clk, .rst_n, .push, .push_job, .full(q_full),
    .pop, .empty(q_empty), .head(q_head)
  );

  frt_back u_back (
    .clk, .rst_n, .hwr, .q_empty, .q_head, .pop, .rel,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .done_frame_id(d_fid), .done_pts(d_pts), .key_frame(d_key),
    .out_handle(d_handle), .out_index(d_index), .last(out_tlast),
    .dropped_frames(d_drops), .full_drops(d_fulls)
  );

  assign out_tdata = {3'd0, d_fulls, d_drops, d_index, d_handle, d_key, d_pts, d_fid};

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full)) else $error("job pushed into full queue");
  a_release_locked: assert property (@(posedge clk) disable iff (!rst_n)
    rel.vld |-> lock[rel.slot]) else $error("release of unlocked slot");
  a_pending_locked: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> lock[q_head.slot]) else $error("queued job slot not locked");
endmodule
